// ===== hw/rtl/rrp_pkg.sv =====
// Shared types and constants for the reply parser.
`timescale 1ns / 1ps
package rrp_pkg;
    localparam int MaxDepth  = 8;
    localparam int LvlW      = 4;
    localparam int SlotW     = 3;

    // Event kind codes.
    localparam logic [3:0] EV_ENTER    = 4'd0;
    localparam logic [3:0] EV_LEAVE    = 4'd1;
    localparam logic [3:0] EV_STS_BYTE = 4'd2;
    localparam logic [3:0] EV_STS_END  = 4'd3;
    localparam logic [3:0] EV_ERR_BYTE = 4'd4;
    localparam logic [3:0] EV_ERR_END  = 4'd5;
    localparam logic [3:0] EV_INTEGER  = 4'd6;
    localparam logic [3:0] EV_NULL     = 4'd7;
    localparam logic [3:0] EV_BLK_BYTE = 4'd8;
    localparam logic [3:0] EV_BLK_END  = 4'd9;
    localparam logic [3:0] EV_ARRAY    = 4'd10;
    localparam logic [3:0] EV_DONE     = 4'd11;
    localparam logic [3:0] EV_FAILED   = 4'd12;

    // Failure status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ERRREPLY = 3'd1;
    localparam logic [2:0] ST_BADFORM  = 3'd2;
    localparam logic [2:0] ST_ENDED    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } t_in;

    typedef struct packed {
        logic [3:0]         event_kind;
        logic [3:0]         depth;
        logic [7:0]         data_byte;
        logic signed [31:0] number;
        logic [2:0]         status;
        logic               last;
    } t_out;
endpackage

// ===== hw/rtl/rrp_mac.sv =====
// Shared multiply-accumulate unit: acc * 10 + digit, or negation of acc.
`timescale 1ns / 1ps
module rrp_mac (
    input  logic [31:0] i_acc,
    input  logic [3:0]  i_digit,
    input  logic        i_negate,
    output logic [31:0] o_result
);
    // One small multiplier by ten for digit steps; the sign step negates acc.
    always_comb begin
        if (i_negate) begin
            o_result = 32'd0 - i_acc;
        end else begin
            o_result = (i_acc * 32'd10) + {28'd0, i_digit};
        end
    end
endmodule

// ===== hw/rtl/resp_reply_parser.sv =====
// Top level of the byte-serial reply parser.
`timescale 1ns / 1ps
//  channel | direction | payload
//  in      | input     | rrp_pkg::t_in  (i_in_valid, o_in_stall)
//  out     | output    | rrp_pkg::t_out (o_out_valid, i_out_stall)
// A byte forms its first event as it is taken, except in the cases below.
// Stream end, a bad integer byte, depth overflow, the last bulk tail byte and the LF of
// an integer line form their first event in a later sequencer step; a negative value
// adds the sign step before it.
// Reset (synchronous, active low) returns the parser to idle awaiting a type byte.
// A stall on the output holds the event register and the sequencer.
module resp_reply_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rrp_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rrp_pkg::t_out o_out
);
    import rrp_pkg::*;

    typedef enum logic [3:0] {
        PH_TYPE, PH_STATUS, PH_ERRTEXT, PH_INT0, PH_INT, PH_BLEN0, PH_BLEN,
        PH_CNT0, PH_CNT, PH_BULK, PH_SKIP
    } t_phase;

    // Sequencer steps for one accepted byte.
    typedef enum logic [2:0] {
        SQ_IDLE, SQ_EMIT, SQ_NEG, SQ_LINE, SQ_FIN, SQ_FAIL
    } t_seq;

    t_phase r_phase, n_phase;
    t_seq   r_seq, n_seq;
    logic   r_neg, n_neg, r_pcr, n_pcr, r_errs, n_errs;
    logic [31:0] r_acc, n_acc, r_blen, n_blen;
    logic [1:0]  r_skip, n_skip;
    logic [LvlW-1:0] r_lvl, n_lvl;
    logic [2:0] r_code, n_code;
    // Follow-on step after a single pending emit.
    t_seq   r_after, n_after;
    logic   r_ov, n_ov;
    t_out   r_out, n_out;
    logic [31:0] stack [MaxDepth];
    logic        st_we;
    logic [SlotW-1:0] st_wa;
    logic [31:0] st_wd;
    logic [3:0]  mac_dig;
    logic        mac_neg;
    logic [31:0] mac_res;
    logic [31:0] dec;
    logic [SlotW-1:0] slot;

    rrp_mac u_mac (.i_acc(r_acc), .i_digit(mac_dig), .i_negate(mac_neg), .o_result(mac_res));

    assign o_in_stall  = (r_seq != SQ_IDLE) || r_ov;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign slot        = r_lvl[SlotW-1:0] - SlotW'(2);
    assign dec         = stack[slot] - 32'd1;

    // Next state: decode a byte or run one sequencer step.
    always_comb begin
        logic [7:0] b;
        logic push;
        logic [31:0] v;
        b = i_in.in_byte;
        n_phase = r_phase; n_seq = r_seq; n_neg = r_neg; n_pcr = r_pcr;
        n_errs = r_errs; n_acc = r_acc; n_blen = r_blen; n_skip = r_skip;
        n_lvl = r_lvl; n_code = r_code; n_after = r_after; n_ov = r_ov;
        n_out = r_out; st_we = 1'b0; st_wa = '0; st_wd = r_acc;
        mac_dig = b[3:0] - 4'd0; mac_neg = 1'b0;
        push = 1'b0; v = r_acc;
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        if (!r_ov || !i_out_stall) begin
            n_out = '0;
            unique case (r_seq)
                SQ_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        if (i_in.end_of_data) begin
                            n_code = ST_ENDED; n_seq = SQ_FAIL;
                        end else begin
                            unique case (r_phase)
                                PH_STATUS, PH_ERRTEXT: begin
                                    n_out.event_kind = (r_phase == PH_STATUS) ?
                                        EV_STS_BYTE : EV_ERR_BYTE;
                                    if (r_pcr && b == 8'd10) begin
                                        n_pcr = 1'b0;
                                        n_out.event_kind = n_out.event_kind + 4'd1;
                                        push = 1'b1; n_after = SQ_FIN;
                                    end else if (r_pcr) begin
                                        n_out.data_byte = 8'd13; push = 1'b1;
                                        n_pcr = (b == 8'd13);
                                        n_after = (b == 8'd13) ? SQ_IDLE : SQ_EMIT;
                                        n_acc = {24'd0, b};
                                    end else if (b == 8'd13) begin
                                        n_pcr = 1'b1;
                                    end else begin
                                        n_out.data_byte = b; push = 1'b1;
                                        n_after = SQ_IDLE;
                                    end
                                end
                                PH_BULK: begin
                                    n_out.event_kind = EV_BLK_BYTE; n_out.data_byte = b;
                                    push = 1'b1; n_blen = r_blen - 32'd1;
                                    if (n_blen == 32'd0) begin
                                        n_after = SQ_EMIT; n_phase = PH_SKIP;
                                        n_skip = 2'd2; n_acc = 32'hFFFF_FFFF;
                                    end else n_after = SQ_IDLE;
                                end
                                PH_SKIP: begin
                                    n_skip = (r_skip != 2'd0) ? r_skip - 2'd1 : r_skip;
                                    if (n_skip == 2'd0) n_seq = SQ_FIN;
                                end
                                PH_TYPE: begin
                                    if (r_lvl >= LvlW'(MaxDepth)) begin
                                        n_code = ST_OVERFLOW; n_seq = SQ_FAIL;
                                    end else begin
                                        n_out.event_kind = EV_ENTER; n_out.depth = r_lvl;
                                        push = 1'b1; n_after = SQ_IDLE;
                                        n_lvl = r_lvl + 4'd1; n_neg = 1'b0;
                                        n_acc = '0; n_pcr = 1'b0;
                                        unique case (b)
                                            8'h2B: n_phase = PH_STATUS;
                                            8'h2D: begin n_phase = PH_ERRTEXT; n_errs = 1'b1; end
                                            8'h3A: n_phase = PH_INT0;
                                            8'h24: n_phase = PH_BLEN0;
                                            8'h2A: n_phase = PH_CNT0;
                                            default: begin
                                                n_code = ST_BADFORM; n_after = SQ_FAIL;
                                            end
                                        endcase
                                    end
                                end
                                default: begin
                                    // Integer line bytes.
                                    if (r_pcr) begin
                                        n_pcr = 1'b0;
                                        if (b == 8'd10) n_seq = r_neg ? SQ_NEG : SQ_LINE;
                                        else begin n_code = ST_BADFORM; n_seq = SQ_FAIL; end
                                    end else if (b == 8'd13) begin
                                        n_pcr = 1'b1;
                                    end else if (r_phase[0] && b == 8'h2D) begin
                                        n_neg = 1'b1; n_phase = t_phase'(r_phase + 4'd1);
                                    end else if (r_phase[0] && b == 8'h2B) begin
                                        n_phase = t_phase'(r_phase + 4'd1);
                                    end else if (b >= 8'h30 && b <= 8'h39) begin
                                        n_acc = mac_res;
                                        if (r_phase[0]) n_phase = t_phase'(r_phase + 4'd1);
                                    end else begin
                                        n_code = ST_BADFORM; n_seq = SQ_FAIL;
                                    end
                                end
                            endcase
                        end
                    end
                end
                SQ_EMIT: begin
                    // Pending second event: bulk end or a held text byte.
                    if (r_phase == PH_SKIP) begin
                        n_out.event_kind = EV_BLK_END;
                    end else begin
                        n_out.event_kind = (r_phase == PH_STATUS) ? EV_STS_BYTE : EV_ERR_BYTE;
                        n_out.data_byte = r_acc[7:0];
                    end
                    push = 1'b1; n_after = SQ_IDLE;
                end
                SQ_NEG: begin
                    mac_neg = 1'b1; n_acc = mac_res; n_neg = 1'b0; n_seq = SQ_LINE;
                end
                SQ_LINE: begin
                    v = r_acc; n_acc = '0; n_neg = 1'b0; push = 1'b1;
                    if (r_phase == PH_INT0 || r_phase == PH_INT) begin
                        n_out.event_kind = EV_INTEGER; n_out.number = v; n_after = SQ_FIN;
                    end else if (r_phase == PH_BLEN0 || r_phase == PH_BLEN) begin
                        if (v[31]) begin
                            n_out.event_kind = EV_NULL; n_after = SQ_FIN;
                        end else if (v == 32'd0) begin
                            n_out.event_kind = EV_BLK_END; n_after = SQ_IDLE;
                            n_phase = PH_SKIP; n_skip = 2'd2;
                        end else begin
                            push = 1'b0; n_blen = v; n_phase = PH_BULK; n_seq = SQ_IDLE;
                        end
                    end else begin
                        n_out.event_kind = EV_ARRAY; n_out.number = v;
                        if (v[31] || v == 32'd0 || r_lvl == '0) n_after = SQ_FIN;
                        else begin
                            st_we = 1'b1; st_wa = SlotW'(r_lvl - 4'd1); st_wd = v;
                            n_phase = PH_TYPE; n_after = SQ_IDLE;
                        end
                    end
                end
                SQ_FIN: begin
                    push = 1'b1;
                    if (r_lvl != '0) begin
                        n_lvl = r_lvl - 4'd1;
                        n_out.event_kind = EV_LEAVE; n_out.depth = n_lvl;
                        n_after = SQ_FIN;
                        if (n_lvl != '0) begin
                            st_we = 1'b1; st_wa = slot; st_wd = dec;
                            if (dec != 32'd0) begin
                                n_phase = PH_TYPE; n_after = SQ_IDLE;
                            end
                        end
                    end else begin
                        n_out.event_kind = r_errs ? EV_FAILED : EV_DONE;
                        n_out.status = r_errs ? ST_ERRREPLY : ST_OK;
                        n_after = SQ_IDLE;
                        n_phase = PH_TYPE; n_neg = 1'b0; n_acc = '0; n_pcr = 1'b0;
                        n_blen = '0; n_skip = '0; n_errs = 1'b0;
                    end
                end
                SQ_FAIL: begin
                    push = 1'b1; n_after = SQ_FAIL;
                    if (r_lvl != '0) begin
                        n_lvl = r_lvl - 4'd1;
                        n_out.event_kind = EV_LEAVE; n_out.depth = n_lvl;
                    end else begin
                        n_out.event_kind = EV_FAILED; n_out.status = r_code;
                        n_after = SQ_IDLE;
                        n_phase = PH_TYPE; n_neg = 1'b0; n_acc = '0; n_pcr = 1'b0;
                        n_blen = '0; n_skip = '0; n_errs = 1'b0;
                    end
                end
                default: n_seq = SQ_IDLE;
            endcase
            if (push) begin
                n_ov = 1'b1; n_seq = n_after;
                n_out.last = (n_after == SQ_IDLE);
            end
        end
    end

    // State, event register and level stack.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE; r_seq <= SQ_IDLE; r_neg <= 1'b0; r_pcr <= 1'b0;
            r_errs <= 1'b0; r_acc <= '0; r_blen <= '0; r_skip <= '0;
            r_lvl <= '0; r_code <= ST_OK; r_after <= SQ_IDLE; r_ov <= 1'b0;
        end else begin
            r_phase <= n_phase; r_seq <= n_seq; r_neg <= n_neg; r_pcr <= n_pcr;
            r_errs <= n_errs; r_acc <= n_acc; r_blen <= n_blen; r_skip <= n_skip;
            r_lvl <= n_lvl; r_code <= n_code; r_after <= n_after; r_ov <= n_ov;
        end
        r_out <= n_out;
        if (st_we) stack[st_wa] <= st_wd;
    end
endmodule

// ===== sim/resp_reply_parser_chk.sv =====
// Event checker for the reply parser: predicts the events of each byte and compares them.
`timescale 1ns / 1ps
module resp_reply_parser_chk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  rrp_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  rrp_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending
);
    import rrp_pkg::*;

    // Decoder phases.
    typedef enum logic [3:0] {
        PH_TYPE, PH_STATUS, PH_ERRTEXT, PH_INT0, PH_INT, PH_BLEN0, PH_BLEN,
        PH_CNT0, PH_CNT, PH_BULK, PH_SKIP
    } t_phase;

    t_phase      phase;
    logic        negative;
    logic [31:0] accum;
    logic        pending_cr;
    logic [31:0] bulk_left;
    logic [1:0]  skip_left;
    logic [31:0] elems_left [MaxDepth];
    int          level;
    logic        err_seen;

    t_out event_queue[$];
    t_out batch[$];

    assign o_pending = event_queue.size();

    // Queue one predicted event for the current byte.
    function automatic void push_event(logic [3:0] kind, int dep, logic [7:0] data,
                                       logic [31:0] num, logic [2:0] st);
        t_out ev;
        ev.event_kind = kind;
        ev.depth      = dep[3:0];
        ev.data_byte  = data;
        ev.number     = num;
        ev.status     = st;
        ev.last       = 1'b0;
        batch.push_back(ev);
    endfunction

    function automatic void clear_reply();
        phase      = PH_TYPE;
        negative   = 1'b0;
        accum      = '0;
        pending_cr = 1'b0;
        bulk_left  = '0;
        skip_left  = '0;
        level      = 0;
        err_seen   = 1'b0;
    endfunction

    function automatic void fail_reply(logic [2:0] code);
        while (level > 0) begin
            level--;
            push_event(EV_LEAVE, level, '0, '0, ST_OK);
        end
        push_event(EV_FAILED, 0, '0, '0, code);
        clear_reply();
    endfunction

    // Close the current element and each parent that it completes.
    function automatic void close_element();
        while (level > 0) begin
            level--;
            push_event(EV_LEAVE, level, '0, '0, ST_OK);
            if (level == 0) break;
            elems_left[level-1] = elems_left[level-1] - 1;
            if (elems_left[level-1] != 0) begin
                phase = PH_TYPE;
                return;
            end
        end
        if (err_seen) push_event(EV_FAILED, 0, '0, '0, ST_ERRREPLY);
        else push_event(EV_DONE, 0, '0, '0, ST_OK);
        clear_reply();
    endfunction

    function automatic void end_number_line();
        logic [31:0] val;
        t_phase      ph;
        val = negative ? -accum : accum;
        ph = phase;
        negative = 1'b0;
        accum = '0;
        if (ph == PH_INT0 || ph == PH_INT) begin
            push_event(EV_INTEGER, 0, '0, val, ST_OK);
            close_element();
        end else if (ph == PH_BLEN0 || ph == PH_BLEN) begin
            if (val[31]) begin
                push_event(EV_NULL, 0, '0, '0, ST_OK);
                close_element();
            end else if (val == 0) begin
                push_event(EV_BLK_END, 0, '0, '0, ST_OK);
                phase = PH_SKIP;
                skip_left = 2'd2;
            end else begin
                bulk_left = val;
                phase = PH_BULK;
            end
        end else begin
            push_event(EV_ARRAY, 0, '0, val, ST_OK);
            if (val[31] || val == 0 || level == 0 || level > MaxDepth) begin
                close_element();
            end else begin
                elems_left[level-1] = val;
                phase = PH_TYPE;
            end
        end
    endfunction

    function automatic void number_byte(logic [7:0] b);
        logic first;
        first = (phase == PH_INT0 || phase == PH_BLEN0 || phase == PH_CNT0);
        if (pending_cr) begin
            pending_cr = 1'b0;
            if (b == 8'd10) end_number_line();
            else fail_reply(ST_BADFORM);
        end else if (b == 8'd13) begin
            pending_cr = 1'b1;
        end else if (first && b == "-") begin
            negative = 1'b1;
            phase = t_phase'(phase + 1);
        end else if (first && b == "+") begin
            phase = t_phase'(phase + 1);
        end else if (b >= "0" && b <= "9") begin
            accum = accum * 10 + 32'(b - "0");
            if (first) phase = t_phase'(phase + 1);
        end else begin
            fail_reply(ST_BADFORM);
        end
    endfunction

    function automatic void text_byte(logic [7:0] b, logic [3:0] byte_kind,
                                      logic [3:0] end_kind);
        if (pending_cr) begin
            pending_cr = 1'b0;
            if (b == 8'd10) begin
                push_event(end_kind, 0, '0, '0, ST_OK);
                close_element();
                return;
            end
            push_event(byte_kind, 0, 8'd13, '0, ST_OK);
        end
        if (b == 8'd13) pending_cr = 1'b1;
        else push_event(byte_kind, 0, b, '0, ST_OK);
    endfunction

    function automatic void type_byte(logic [7:0] b);
        if (level >= MaxDepth) begin
            fail_reply(ST_OVERFLOW);
            return;
        end
        push_event(EV_ENTER, level, '0, '0, ST_OK);
        level++;
        negative = 1'b0;
        accum = '0;
        pending_cr = 1'b0;
        case (b)
            "+": phase = PH_STATUS;
            "-": begin
                phase = PH_ERRTEXT;
                err_seen = 1'b1;
            end
            ":": phase = PH_INT0;
            "$": phase = PH_BLEN0;
            "*": phase = PH_CNT0;
            default: fail_reply(ST_BADFORM);
        endcase
    endfunction

    // Work out every event of one accepted byte and queue them.
    function automatic void predict_events(t_in it);
        batch.delete();
        if (it.end_of_data) begin
            fail_reply(ST_ENDED);
        end else begin
            case (phase)
                PH_STATUS: text_byte(it.in_byte, EV_STS_BYTE, EV_STS_END);
                PH_ERRTEXT: text_byte(it.in_byte, EV_ERR_BYTE, EV_ERR_END);
                PH_INT0, PH_INT, PH_BLEN0, PH_BLEN, PH_CNT0, PH_CNT:
                    number_byte(it.in_byte);
                PH_BULK: begin
                    push_event(EV_BLK_BYTE, 0, it.in_byte, '0, ST_OK);
                    bulk_left = bulk_left - 1;
                    if (bulk_left == 0) begin
                        push_event(EV_BLK_END, 0, '0, '0, ST_OK);
                        phase = PH_SKIP;
                        skip_left = 2'd2;
                    end
                end
                PH_SKIP: begin
                    if (skip_left > 0) skip_left--;
                    if (skip_left == 0) close_element();
                end
                default: type_byte(it.in_byte);
            endcase
        end
        if (batch.size() > 12) batch = batch[0:11];
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[k]) event_queue.push_back(batch[k]);
    endfunction

    // Watch both channels at each edge.
    always @(posedge i_clk) begin
        t_out exp_ev;
        if (!i_rst_n) begin
            clear_reply();
            event_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (event_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected event %p", i_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_ev = event_queue.pop_front();
                    if (i_out !== exp_ev) begin
                        if (o_fail_count < 10)
                            $display("ERROR: event mismatch, expected %p, got %p",
                                     exp_ev, i_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_events(i_in);
        end
    end
endmodule

// ===== sim/resp_reply_parser_tb.sv =====
// Testbench top for the reply parser: drives reply streams and gives the verdict.
`timescale 1ns / 1ps
module resp_reply_parser_tb;
    import rrp_pkg::*;

    localparam int IdleLimit = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_item;
    int   fail_count;
    int   pending;
    bit   quiet_phase = 1'b0;
    int   idle_cycles = 0;
    t_in  byte_stream[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    resp_reply_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    resp_reply_parser_chk chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver stalls in random bursts.
    always @(posedge i_clk) begin
        int burst;
        if (quiet_phase || !i_rst_n) begin
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 17);
            out_stall <= 1'b1;
            repeat (burst) @(posedge i_clk);
            out_stall <= 1'b0;
        end
    end

    function automatic void add_byte(logic [7:0] b);
        t_in it;
        it.in_byte = b;
        it.end_of_data = 1'b0;
        byte_stream.push_back(it);
    endfunction

    function automatic void add_text(string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endfunction

    function automatic void add_end();
        t_in it;
        it.in_byte = 8'($urandom);
        it.end_of_data = 1'b1;
        byte_stream.push_back(it);
    endfunction

    function automatic void add_crlf();
        add_byte(8'd13);
        add_byte(8'd10);
    endfunction

    // Random number text, sometimes signed, sometimes long enough to wrap.
    function automatic void add_number(int hi);
        int n;
        case ($urandom_range(0, 7))
            0: add_byte("-");
            1: add_byte("+");
            default: ;
        endcase
        n = $urandom_range(0, 5) == 0 ? $urandom_range(0, 12) : 0;
        if (n > 0) begin
            for (int k = 0; k < n; k++) add_byte(8'("0" + $urandom_range(0, 9)));
        end else begin
            add_text($sformatf("%0d", $urandom_range(0, hi)));
        end
    endfunction

    function automatic void add_text_body();
        int n;
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) add_byte(8'd13);
            else add_byte(8'($urandom_range(0, 255)) & 8'hf7 | 8'h20);
        end
    endfunction

    // Random element, well-formed but for null arrays; arrays nest at most to d.
    function automatic void add_element(int d);
        int n;
        case ($urandom_range(0, 5))
            0: begin add_byte("+"); add_text_body(); add_crlf(); end
            1: begin add_byte("-"); add_text_body(); add_crlf(); end
            2: begin add_byte(":"); add_number(99999); add_crlf(); end
            3: begin
                add_byte("$");
                if ($urandom_range(0, 5) == 0) begin
                    add_text("-1");
                    add_crlf();
                end else begin
                    n = $urandom_range(0, 4);
                    add_text($sformatf("%0d", n));
                    add_crlf();
                    for (int k = 0; k < n; k++) add_byte(8'($urandom));
                    add_byte(8'($urandom));
                    add_byte(8'($urandom));
                end
            end
            default: begin
                add_byte("*");
                n = (d > 0) ? $urandom_range(0, 3) : 0;
                if ($urandom_range(0, 9) == 0) add_text("-1");
                else add_text($sformatf("%0d", n));
                add_crlf();
                for (int k = 0; k < n; k++) add_element(d - 1);
            end
        endcase
    endfunction

    // Directed streams: every reply form, extremes and the named corner cases.
    function automatic void add_directed();
        add_text("+OK"); add_byte(8'd13); add_byte("x"); add_crlf();
        add_text("-E"); add_crlf();
        add_text(":-2147483648"); add_crlf();
        add_text(":"); add_crlf();
        add_text(":99999999999"); add_crlf();
        add_text("$-1"); add_crlf();
        add_text("$0"); add_crlf(); add_byte(8'hff); add_byte(8'h00);
        add_text("$2"); add_crlf(); add_byte(8'hff); add_byte(8'h00); add_crlf();
        add_text("*0"); add_crlf();
        add_text("*-1"); add_crlf();
        add_text(":1x");
        add_byte(8'hA5);
        add_text(":"); add_byte(8'd13); add_byte(8'd0);
        add_end();
        add_text("+a"); add_end();
        for (int k = 0; k < 9; k++) add_text("*1\r\n");
        add_text("*2\r\n:1\r\n*1\r\n+\r\n");
    endfunction

    // Drive the stream with random sender gaps.
    task automatic send_stream();
        while (byte_stream.size() > 0) begin
            if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            in_item <= byte_stream.pop_front();
            in_valid <= 1'b1;
            @(posedge i_clk);
            while (in_stall) @(posedge i_clk);
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        int total;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        add_directed();
        total = byte_stream.size();
        send_stream();
        while (total < 370) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
                end
                1: begin
                    add_element(2);
                    void'(byte_stream.pop_back());
                    add_end();
                end
                default: add_element(3);
            endcase
            total += byte_stream.size();
            if (total > 300) quiet_phase = 1'b1;
            send_stream();
        end
        add_end();
        send_stream();
        while (pending > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/rrp_pkg.sv
hw/rtl/rrp_mac.sv
hw/rtl/resp_reply_parser.sv
sim/resp_reply_parser_chk.sv
sim/resp_reply_parser_tb.sv
